>>> sv/snz_pkg.sv
// shared constants, request codes and gradient helper for the simplex noise evaluator
package snz_pkg;

  // permutation table geometry
  localparam int TABLE_SIZE    = 256;
  localparam int AW            = 8;
  localparam int FRAC_BITS_DEF = 16;

  // corner offsets are Q.24 taken modulo 2^XW (true values stay well inside)
  localparam int XW  = 28;
  localparam int DW  = XW + 2;   // gradient dot product
  localparam int CW  = 56;       // one corner contribution, Q.48
  localparam int TW  = CW + 2;   // radial term before the sign test
  localparam int SW  = CW + 2;   // sum of four corners
  localparam int SCW = SW + 7;   // scaled sum
  localparam int OW  = 18;       // result width

  localparam logic signed [XW-1:0] ONE_Q24       = 28'sd16777216;
  localparam logic signed [23:0]   SKEW2_Q24     = 24'sd6140887;
  localparam logic signed [XW-1:0] UNSKEW2_Q24   = 28'sd3545443;
  localparam logic signed [XW-1:0] UNSKEW2X2_Q24 = 28'sd7090886;
  localparam logic signed [XW-1:0] UNSKEW3_Q24   = 28'sd2796203;
  localparam logic signed [XW-1:0] UNSKEW3X2_Q24 = 28'sd5592405;
  localparam logic signed [XW-1:0] UNSKEW3X3_Q24 = 28'sd8388608;
  localparam logic signed [CW-1:0] RAD2_Q48      = {8'd0, 24'd8388608, 24'd0};
  localparam logic signed [CW-1:0] RAD3_Q48      = {8'd0, 24'd10066330, 24'd0};
  localparam logic [31:0]          DIV3_MAGIC    = 32'hAAAAAAAB;
  localparam logic signed [OW-1:0] OUT_MAX       = 18'sd65536;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_EVAL2 = 2'd1,
    REQ_EVAL3 = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // dot product of offset with gradient (hash mod 12)
  function automatic logic signed [DW-1:0] grad_dot(input logic [AW-1:0] h,
                                                    input logic signed [XW-1:0] dx,
                                                    input logic signed [XW-1:0] dy,
                                                    input logic signed [XW-1:0] dz);
    logic [15:0]           prod;
    logic [4:0]            q;
    logic [7:0]            r;
    logic signed [DW-1:0]  pa;
    logic signed [DW-1:0]  pb;
    prod = 16'(h) * 16'd171;
    q    = prod[15:11];
    r    = h - ({q, 3'b000} + {1'b0, q, 2'b00});
    case (r[3:2])
      2'd0: begin
        pa = DW'(dx);
        pb = DW'(dy);
      end
      2'd1: begin
        pa = DW'(dx);
        pb = DW'(dz);
      end
      default: begin
        pa = DW'(dy);
        pb = DW'(dz);
      end
    endcase
    return (r[0] ? -pa : pa) + (r[1] ? -pb : pb);
  endfunction

endpackage

>>> sv/snz_perm_ram.sv
// permutation table copy: one write port, two registered read ports
module snz_perm_ram import snz_pkg::*; (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [7:0]    rdata_a,
  output logic [7:0]    rdata_b
);

  logic [7:0] mem [TABLE_SIZE];
  logic [7:0] rdata_a_r;
  logic [7:0] rdata_b_r;

  // table write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> sv/snz_corner.sv
// one simplex corner: radial falloff to the fourth power times gradient dot
module snz_corner import snz_pkg::*; (
  input  logic                 clk,
  input  logic signed [XW-1:0] dx,
  input  logic signed [XW-1:0] dy,
  input  logic signed [XW-1:0] dz,
  input  logic                 rad3,
  input  logic                 en,
  input  logic [AW-1:0]        hash,
  output logic signed [CW-1:0] contrib
);

  logic signed [XW-1:0]   d1_r [3];
  logic signed [2*XW-1:0] sq1_r [3];
  logic                   rad3_1_r;
  logic                   en1_r;
  logic signed [XW-1:0]   d2_r [3];
  logic [23:0]            t2_r;
  logic                   pos2_r;
  logic signed [XW-1:0]   d3_r [3];
  logic [47:0]            tt3_r;
  logic                   pos3_r;
  logic [47:0]            t22_4_r;
  logic signed [DW-1:0]   dot4_r;
  logic                   pos4_r;
  logic signed [CW-1:0]   contrib_r;
  logic signed [TW-1:0]   t_nxt;
  logic [23:0]            t4;

  // squared distances
  always_ff @(posedge clk) begin
    d1_r[0]  <= dx;
    d1_r[1]  <= dy;
    d1_r[2]  <= dz;
    sq1_r[0] <= dx * dx;
    sq1_r[1] <= dy * dy;
    sq1_r[2] <= dz * dz;
    rad3_1_r <= rad3;
    en1_r    <= en;
  end

  // radial term, floored to q.24
  always_comb begin
    t_nxt = TW'(rad3_1_r ? RAD3_Q48 : RAD2_Q48) - TW'(sq1_r[0]) - TW'(sq1_r[1])
            - TW'(sq1_r[2]);
  end

  always_ff @(posedge clk) begin
    d2_r   <= d1_r;
    t2_r   <= t_nxt[47:24];
    pos2_r <= en1_r && !t_nxt[TW-1];
  end

  // square of the radial term
  always_ff @(posedge clk) begin
    d3_r   <= d2_r;
    tt3_r  <= t2_r * t2_r;
    pos3_r <= pos2_r;
  end

  // fourth power and gradient dot, hash arrives here
  always_ff @(posedge clk) begin
    t22_4_r <= tt3_r[47:24] * tt3_r[47:24];
    dot4_r  <= grad_dot(hash, d3_r[0], d3_r[1], d3_r[2]);
    pos4_r  <= pos3_r;
  end

  // weighted contribution
  assign t4 = t22_4_r[47:24];

  always_ff @(posedge clk) begin
    contrib_r <= pos4_r ? CW'(signed'({1'b0, t4})) * CW'(dot4_r) : '0;
  end

  assign contrib = contrib_r;

endmodule

>>> sv/simplex_noise_2d_3d.sv
// simplex noise evaluator top: skew, cell, corner order, hashing, corner sum, scaling
// result strobed on out_valid after kind_r[1] to kind_r[NST] and the output register
// throughput: one item per cycle; busy stays low, every stage advances each cycle
// the table hash is three chained registered reads (two in 2d) from replicated table copies
// reset (rst_n low, synchronous) empties the pipeline; table contents stay undefined
// until loaded, and no result is ever held back since the receiver cannot stall
module simplex_noise_2d_3d import snz_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_req_type,
  input  logic [7:0]           in_entry_index,
  input  logic [7:0]           in_entry_value,
  input  logic signed [31:0]   in_x_coord,
  input  logic signed [31:0]   in_y_coord,
  input  logic signed [31:0]   in_z_coord,
  output logic                 out_valid,
  output logic signed [OW-1:0] out_noise_value
);

  localparam int AXW = 35;                  // 4x + y + z
  localparam int NW  = AXW - FRAC_BITS;     // that sum over 2^frac
  localparam int QW  = NW + 32;             // divide-by-three product
  localparam int PW  = 58;                  // 2d skewed coordinate, q.(frac+24)
  localparam int IW  = PW - 24 - FRAC_BITS; // 2d cell coordinate
  localparam int CIW = NW + 1;              // common cell coordinate
  localparam int NST = 14;

  // control pipeline
  req_t                  kind_r [1:NST];
  logic                  out_valid_r;
  logic signed [OW-1:0]  out_noise_r;
  logic [7:0]            ld_idx_r [1:9];
  logic [7:0]            ld_val_r [1:9];

  // datapath registers
  logic signed [31:0]    crd1_r [3];
  logic signed [31:0]    crd2_r [3];
  logic signed [31:0]    crd3_r [3];
  logic signed [31:0]    crd4_r [3];
  logic signed [56:0]    m2_1_r;
  logic signed [AXW-1:0] ax1_r [3];
  logic [NW-1:0]         u2_r [3];
  logic                  neg2_r [3];
  logic signed [IW-1:0]  i2d2_r [2];
  logic [QW-1:0]         q3_r [3];
  logic                  neg3_r [3];
  logic signed [IW-1:0]  i2d3_r [2];
  logic signed [CIW-1:0] c4_r [3];
  logic signed [XW-1:0]  tsum5_r;
  logic signed [XW-1:0]  xs5_r [3];
  logic [AW-1:0]         cb5_r [3];
  logic signed [XW-1:0]  x06_r [3];
  logic [AW-1:0]         cb6_r [3];
  logic signed [XW-1:0]  d7_r [4][3];
  logic [AW-1:0]         a7_r [4][3];
  logic [3:0]            en7_r;
  logic [AW-1:0]         ai8_r [4];
  logic [AW-1:0]         b8_r [4];
  logic [AW-1:0]         ai9_r [4];
  logic [7:0]            l2d10_r [4];
  logic signed [SW-1:0]  sum13_r;
  logic signed [SCW-1:0] sc14_r;

  // combinational values
  logic signed [32:0]    sxy;
  logic signed [AXW-1:0] ax_nxt [3];
  logic [NW-1:0]         u_nxt [3];
  logic                  neg_nxt [3];
  logic signed [IW-1:0]  i2d_nxt [2];
  logic signed [CIW-1:0] c_nxt [3];
  logic signed [XW-1:0]  tsum_nxt;
  logic signed [XW-1:0]  d_nxt [4][3];
  logic [AW-1:0]         a_nxt [4][3];
  logic [3:0]            en_nxt;
  logic [AW-1:0]         rd_addr [3][4];
  logic [7:0]            rd_data [3][4];
  logic [AW-1:0]         hash [4];
  logic signed [CW-1:0]  contrib [4];
  logic signed [SCW-1:0] sc_nxt;
  logic signed [SCW-33:0] v_nxt;
  logic signed [OW-1:0]  noise_nxt;

  assign busy = 1'b0;

  // request kind travels with the data; loads carry index and value to the tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= NST; k++) begin
        kind_r[k] <= REQ_NONE;
      end
      out_valid_r <= 1'b0;
    end else begin
      kind_r[1] <= (start && !busy) ? req_t'(in_req_type) : REQ_NONE;
      for (int k = 2; k <= NST; k++) begin
        kind_r[k] <= kind_r[k-1];
      end
      out_valid_r <= (kind_r[NST] == REQ_EVAL2) || (kind_r[NST] == REQ_EVAL3);
    end
  end

  always_ff @(posedge clk) begin
    ld_idx_r[1] <= in_entry_index;
    ld_val_r[1] <= in_entry_value;
    for (int k = 2; k <= 9; k++) begin
      ld_idx_r[k] <= ld_idx_r[k-1];
      ld_val_r[k] <= ld_val_r[k-1];
    end
  end

  // stage 1: 2d skew product, 3d skew sums
  assign sxy = 33'(in_x_coord) + 33'(in_y_coord);

  always_comb begin
    ax_nxt[0] = (AXW'(in_x_coord) <<< 2) + (AXW'(in_y_coord) + AXW'(in_z_coord));
    ax_nxt[1] = (AXW'(in_y_coord) <<< 2) + (AXW'(in_x_coord) + AXW'(in_z_coord));
    ax_nxt[2] = (AXW'(in_z_coord) <<< 2) + (AXW'(in_x_coord) + AXW'(in_y_coord));
  end

  always_ff @(posedge clk) begin
    crd1_r[0] <= in_x_coord;
    crd1_r[1] <= in_y_coord;
    crd1_r[2] <= in_z_coord;
    m2_1_r    <= sxy * SKEW2_Q24;
    ax1_r     <= ax_nxt;
  end

  // stage 2: 2d cell by floor shift, 3d floor over 2^frac and sign fold
  always_comb begin
    logic signed [PW-1:0] px;
    logic signed [NW-1:0] n;
    for (int a = 0; a < 2; a++) begin
      px         = (PW'(crd1_r[a]) <<< 24) + PW'(m2_1_r);
      i2d_nxt[a] = IW'(px >>> (24 + FRAC_BITS));
    end
    for (int a = 0; a < 3; a++) begin
      n          = NW'(ax1_r[a] >>> FRAC_BITS);
      neg_nxt[a] = n[NW-1];
      u_nxt[a]   = n[NW-1] ? (NW'(2) - NW'(n)) : NW'(n);
    end
  end

  always_ff @(posedge clk) begin
    crd2_r <= crd1_r;
    u2_r   <= u_nxt;
    neg2_r <= neg_nxt;
    i2d2_r <= i2d_nxt;
  end

  // stage 3: divide by three via reciprocal multiply
  always_ff @(posedge clk) begin
    crd3_r <= crd2_r;
    neg3_r <= neg2_r;
    i2d3_r <= i2d2_r;
    for (int a = 0; a < 3; a++) begin
      q3_r[a] <= QW'(u2_r[a]) * QW'(DIV3_MAGIC);
    end
  end

  // stage 4: cell coordinates
  always_comb begin
    logic signed [CIW-1:0] qd;
    for (int a = 0; a < 3; a++) begin
      qd = CIW'(q3_r[a] >> 33);
      if (kind_r[3] == REQ_EVAL3) begin
        c_nxt[a] = neg3_r[a] ? -qd : qd;
      end else if (a < 2) begin
        c_nxt[a] = CIW'(i2d3_r[a]);
      end else begin
        c_nxt[a] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    crd4_r <= crd3_r;
    c4_r   <= c_nxt;
  end

  // stage 5: unskew term and coordinate minus cell, both modulo 2^XW
  always_comb begin
    logic signed [XW-1:0] csum;
    csum     = XW'(c4_r[0]) + XW'(c4_r[1]) + XW'(c4_r[2]);
    tsum_nxt = csum * ((kind_r[4] == REQ_EVAL3) ? UNSKEW3_Q24 : UNSKEW2_Q24);
  end

  always_ff @(posedge clk) begin
    tsum5_r <= tsum_nxt;
    for (int a = 0; a < 3; a++) begin
      xs5_r[a] <= XW'(56'(crd4_r[a]) <<< (24 - FRAC_BITS)) - {c4_r[a][3:0], 24'd0};
      cb5_r[a] <= c4_r[a][AW-1:0];
    end
  end

  // stage 6: first corner offsets
  always_ff @(posedge clk) begin
    cb6_r <= cb5_r;
    for (int a = 0; a < 3; a++) begin
      x06_r[a] <= xs5_r[a] + tsum5_r;
    end
  end

  // stage 7: corner order, corner offsets and hash coordinates
  always_comb begin
    logic [2:0]           ocor [4];
    logic signed [XW-1:0] gofs [4];
    logic                 is3d;
    is3d    = (kind_r[6] == REQ_EVAL3);
    ocor[0] = 3'b000;
    ocor[3] = 3'b111;
    if (is3d) begin
      if (x06_r[0] >= x06_r[1]) begin
        if (x06_r[1] >= x06_r[2]) begin
          ocor[1] = 3'b001;
          ocor[2] = 3'b011;
        end else if (x06_r[0] >= x06_r[2]) begin
          ocor[1] = 3'b001;
          ocor[2] = 3'b101;
        end else begin
          ocor[1] = 3'b100;
          ocor[2] = 3'b101;
        end
      end else begin
        if (x06_r[1] < x06_r[2]) begin
          ocor[1] = 3'b100;
          ocor[2] = 3'b110;
        end else if (x06_r[0] < x06_r[2]) begin
          ocor[1] = 3'b010;
          ocor[2] = 3'b110;
        end else begin
          ocor[1] = 3'b010;
          ocor[2] = 3'b011;
        end
      end
      gofs[0] = '0;
      gofs[1] = UNSKEW3_Q24;
      gofs[2] = UNSKEW3X2_Q24;
      gofs[3] = UNSKEW3X3_Q24;
    end else begin
      ocor[1] = (x06_r[0] > x06_r[1]) ? 3'b001 : 3'b010;
      ocor[2] = 3'b011;
      gofs[0] = '0;
      gofs[1] = UNSKEW2_Q24;
      gofs[2] = UNSKEW2X2_Q24;
      gofs[3] = '0;
    end
    for (int c = 0; c < 4; c++) begin
      en_nxt[c] = is3d || (c < 3);
      for (int a = 0; a < 3; a++) begin
        if (!is3d && a == 2) begin
          d_nxt[c][a] = '0;
        end else begin
          d_nxt[c][a] = x06_r[a] - (ocor[c][a] ? ONE_Q24 : '0) + gofs[c];
        end
        a_nxt[c][a] = cb6_r[a] + AW'(ocor[c][a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    d7_r  <= d_nxt;
    a7_r  <= a_nxt;
    en7_r <= en_nxt;
  end

  // chained table reads: innermost coordinate first
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      rd_addr[0][c] = (kind_r[7] == REQ_EVAL3) ? a7_r[c][2] : a7_r[c][1];
      rd_addr[1][c] = b8_r[c] + rd_data[0][c];
      rd_addr[2][c] = ai9_r[c] + rd_data[1][c];
      hash[c]       = (kind_r[10] == REQ_EVAL3) ? rd_data[2][c] : l2d10_r[c];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      ai8_r[c]   <= a7_r[c][0];
      b8_r[c]    <= (kind_r[7] == REQ_EVAL3) ? a7_r[c][1] : a7_r[c][0];
      ai9_r[c]   <= ai8_r[c];
      l2d10_r[c] <= rd_data[1][c];
    end
  end

  // table copies, each written as a load passes its read stage
  for (genvar lv = 0; lv < 3; lv++) begin : g_level
    for (genvar pr = 0; pr < 2; pr++) begin : g_pair
      snz_perm_ram u_ram (
        .clk     (clk),
        .we      (kind_r[7+lv] == REQ_LOAD),
        .waddr   (ld_idx_r[7+lv]),
        .wdata   (ld_val_r[7+lv]),
        .raddr_a (rd_addr[lv][2*pr]),
        .raddr_b (rd_addr[lv][2*pr+1]),
        .rdata_a (rd_data[lv][2*pr]),
        .rdata_b (rd_data[lv][2*pr+1])
      );
    end
  end

  // corner units
  for (genvar c = 0; c < 4; c++) begin : g_corner
    snz_corner u_corner (
      .clk     (clk),
      .dx      (d7_r[c][0]),
      .dy      (d7_r[c][1]),
      .dz      (d7_r[c][2]),
      .rad3    (kind_r[7] == REQ_EVAL3),
      .en      (en7_r[c]),
      .hash    (hash[c]),
      .contrib (contrib[c])
    );
  end

  // stage 13: corner sum
  always_ff @(posedge clk) begin
    sum13_r <= SW'(contrib[0]) + SW'(contrib[1]) + SW'(contrib[2]) + SW'(contrib[3]);
  end

  // stage 14: scale by 70 or 32 and add rounding half
  always_comb begin
    logic signed [SCW-1:0] s;
    s = SCW'(sum13_r);
    if (kind_r[13] == REQ_EVAL3) begin
      sc_nxt = (s <<< 5) + (SCW'(1) <<< 31);
    end else begin
      sc_nxt = (s <<< 6) + (s <<< 2) + (s <<< 1) + (SCW'(1) <<< 31);
    end
  end

  always_ff @(posedge clk) begin
    sc14_r <= sc_nxt;
  end

  // stage 15: drop to q.16 and saturate to [-1, 1]
  always_comb begin
    v_nxt = (SCW-32)'(sc14_r >>> 32);
    if (v_nxt > (SCW-32)'(OUT_MAX)) begin
      noise_nxt = OUT_MAX;
    end else if (v_nxt < -((SCW-32)'(OUT_MAX))) begin
      noise_nxt = -OUT_MAX;
    end else begin
      noise_nxt = OW'(v_nxt);
    end
  end

  always_ff @(posedge clk) begin
    out_noise_r <= noise_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;

endmodule

>>> tb/testbench.sv
// self-checking testbench for the simplex noise evaluator with a fixed-point noise predictor
`timescale 1ns / 100ps

module testbench;
  import snz_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int RANDOM_ITEMS   = 1280;

  // noise predictor and queue of expected noise values
  class noise_scoreboard;
    byte unsigned perm[256];
    logic signed [17:0] pending_noise[$];
    int mismatches;

    function new();
      foreach (perm[n]) perm[n] = 0;
      mismatches = 0;
    endfunction

    function int unsigned lookup(longint idx);
      return perm[idx & 255];
    endfunction

    function longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    // offset from the cell corner, Q.16 to Q.24
    function longint offset_q24(longint coord, longint c);
      return (coord - c * 65536) * 256;
    endfunction

    function longint grad_dot(int unsigned h, longint dx, longint dy, longint dz);
      case (h % 12)
        0: return dx + dy;
        1: return -dx + dy;
        2: return dx - dy;
        3: return -dx - dy;
        4: return dx + dz;
        5: return -dx + dz;
        6: return dx - dz;
        7: return -dx - dz;
        8: return dy + dz;
        9: return -dy + dz;
        10: return dy - dz;
        default: return -dy - dz;
      endcase
    endfunction

    // one corner contribution in Q.48
    function longint corner_q48(longint rad, longint dx, longint dy, longint dz,
                                int unsigned h);
      longint t, t2, t4;
      t = rad - dx * dx - dy * dy - dz * dz;
      if (t < 0) return 0;
      t  = t >>> 24;
      t2 = (t * t) >>> 24;
      t4 = (t2 * t2) >>> 24;
      return t4 * grad_dot(h, dx, dy, dz);
    endfunction

    // scale, round half up to Q.16 and saturate
    function logic signed [17:0] scale_sat(longint sum, longint scale);
      longint v;
      v = (sum * scale + (64'sd1 <<< 31)) >>> 32;
      if (v > 65536) v = 65536;
      if (v < -65536) v = -65536;
      return 18'(v);
    endfunction

    function logic signed [17:0] noise2(longint x, longint y);
      longint i, j, t, x0, y0, i1, j1, sum;
      longint one, g2;
      one = 64'sd16777216;
      g2  = 64'sd3545443;
      i = (x * one + (x + y) * 64'sd6140887) >>> 40;
      j = (y * one + (x + y) * 64'sd6140887) >>> 40;
      t = (i + j) * g2;
      x0 = offset_q24(x, i) + t;
      y0 = offset_q24(y, j) + t;
      i1 = (x0 > y0) ? 1 : 0;
      j1 = 1 - i1;
      sum = corner_q48(64'sd1 <<< 47, x0, y0, 0, lookup(i + lookup(j)));
      sum += corner_q48(64'sd1 <<< 47, x0 - i1 * one + g2, y0 - j1 * one + g2, 0,
                        lookup(i + i1 + lookup(j + j1)));
      sum += corner_q48(64'sd1 <<< 47, x0 - one + 2 * g2, y0 - one + 2 * g2, 0,
                        lookup(i + 1 + lookup(j + 1)));
      return scale_sat(sum, 70);
    endfunction

    function int unsigned hash3(longint i, longint j, longint k);
      return lookup(i + lookup(j + lookup(k)));
    endfunction

    function logic signed [17:0] noise3(longint x, longint y, longint z);
      longint den, s3, i, j, k, t, x0, y0, z0, sum, rad, one, g1, g2, g3;
      longint i1, j1, k1, i2, j2, k2;
      one = 64'sd16777216;
      g1  = 64'sd2796203;
      g2  = 64'sd5592405;
      g3  = 64'sd8388608;
      rad = 64'sd10066330 * one;
      den = 64'sd3 <<< 16;
      s3  = x + y + z;
      i = floor_div(3 * x + s3, den);
      j = floor_div(3 * y + s3, den);
      k = floor_div(3 * z + s3, den);
      t = (i + j + k) * g1;
      x0 = offset_q24(x, i) + t;
      y0 = offset_q24(y, j) + t;
      z0 = offset_q24(z, k) + t;
      // corner ordering by offset rank
      if (x0 >= y0) begin
        if (y0 >= z0) begin
          {i1, j1, k1, i2, j2, k2} = {64'd1, 64'd0, 64'd0, 64'd1, 64'd1, 64'd0};
        end else if (x0 >= z0) begin
          {i1, j1, k1, i2, j2, k2} = {64'd1, 64'd0, 64'd0, 64'd1, 64'd0, 64'd1};
        end else begin
          {i1, j1, k1, i2, j2, k2} = {64'd0, 64'd0, 64'd1, 64'd1, 64'd0, 64'd1};
        end
      end else begin
        if (y0 < z0) begin
          {i1, j1, k1, i2, j2, k2} = {64'd0, 64'd0, 64'd1, 64'd0, 64'd1, 64'd1};
        end else if (x0 < z0) begin
          {i1, j1, k1, i2, j2, k2} = {64'd0, 64'd1, 64'd0, 64'd0, 64'd1, 64'd1};
        end else begin
          {i1, j1, k1, i2, j2, k2} = {64'd0, 64'd1, 64'd0, 64'd1, 64'd1, 64'd0};
        end
      end
      sum = corner_q48(rad, x0, y0, z0, hash3(i, j, k));
      sum += corner_q48(rad, x0 - i1 * one + g1, y0 - j1 * one + g1, z0 - k1 * one + g1,
                        hash3(i + i1, j + j1, k + k1));
      sum += corner_q48(rad, x0 - i2 * one + g2, y0 - j2 * one + g2, z0 - k2 * one + g2,
                        hash3(i + i2, j + j2, k + k2));
      sum += corner_q48(rad, x0 - one + g3, y0 - one + g3, z0 - one + g3,
                        hash3(i + 1, j + 1, k + 1));
      return scale_sat(sum, 32);
    endfunction

    // accepted input transfer
    function void note_item(logic [1:0] req, logic [7:0] idx, logic [7:0] val,
                            logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
      case (req)
        REQ_LOAD:  perm[idx] = val;
        REQ_EVAL2: pending_noise.push_back(noise2(longint'(x), longint'(y)));
        REQ_EVAL3: pending_noise.push_back(noise3(longint'(x), longint'(y), longint'(z)));
        default: ;
      endcase
    endfunction

    // accepted result transfer
    function void check_noise(logic signed [17:0] got);
      logic signed [17:0] want;
      if (pending_noise.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result noise_value=%0d", got);
        return;
      end
      want = pending_noise.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("noise_value mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_req_type = REQ_NONE;
  logic [7:0] in_entry_index = '0;
  logic [7:0] in_entry_value = '0;
  logic signed [31:0] in_x_coord = '0;
  logic signed [31:0] in_y_coord = '0;
  logic signed [31:0] in_z_coord = '0;
  logic out_valid;
  logic signed [17:0] out_noise_value;

  noise_scoreboard sb = new();
  int idle_cycles = 0;

  simplex_noise_2d_3d uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_entry_index(in_entry_index),
    .in_entry_value(in_entry_value), .in_x_coord(in_x_coord),
    .in_y_coord(in_y_coord), .in_z_coord(in_z_coord),
    .out_valid(out_valid), .out_noise_value(out_noise_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      sb.note_item(in_req_type, in_entry_index, in_entry_value,
                   in_x_coord, in_y_coord, in_z_coord);
    if (rst_n && out_valid) sb.check_noise(out_noise_value);
    if ((rst_n && start && !busy) || (rst_n && out_valid)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // drive one item until accepted, then sometimes an idle gap
  task automatic send_item(logic [1:0] req, logic [7:0] idx, logic [7:0] val,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    start          <= 1'b1;
    in_req_type    <= req;
    in_entry_index <= idx;
    in_entry_value <= val;
    in_x_coord     <= x;
    in_y_coord     <= y;
    in_z_coord     <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // coordinate mostly within 512 cells of the origin, sometimes anywhere
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 64)) - 32) << 16;
      2: return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
      default: return 32'($signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh1FFFFFF);
    endcase
  endfunction

  initial begin
    int r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole table with an affine permutation (n * 151 + 17) before any evaluation
    for (int n = 0; n < 256; n++)
      send_item(REQ_LOAD, 8'(n), 8'((n * 151 + 17) & 255), $urandom, $urandom, $urandom);

    // directed: extremes, exact negative integers, both dimensions, unused code
    send_item(REQ_EVAL2, 8'd0, 8'd0, 32'h0, 32'h0, 32'h0);
    send_item(REQ_EVAL3, 8'd0, 8'd0, 32'h0, 32'h0, 32'h0);
    send_item(REQ_EVAL2, 8'd0, 8'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0);
    send_item(REQ_EVAL2, 8'd0, 8'd0, 32'h80000000, 32'h80000000, 32'hFFFFFFFF);
    send_item(REQ_EVAL3, 8'd0, 8'd0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_item(REQ_EVAL3, 8'd0, 8'd0, 32'h80000000, 32'h80000000, 32'h80000000);
    send_item(REQ_EVAL3, 8'd0, 8'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_item(REQ_EVAL2, 8'd0, 8'd0, 32'hFFFF0000, 32'hFFFE0000, 32'h0);
    send_item(REQ_EVAL3, 8'd0, 8'd0, 32'hFFFF0000, 32'hFFFD0000, 32'hFFFF0000);
    send_item(REQ_EVAL2, 8'd0, 8'd0, 32'hFFFFFFFF, 32'h00000001, 32'h0);
    send_item(REQ_EVAL3, 8'd0, 8'd0, 32'h00008000, 32'hFFFF8000, 32'h00004000);
    send_item(REQ_NONE, 8'hFF, 8'hFF, 32'h12345678, 32'h0, 32'h0);
    send_item(REQ_EVAL2, 8'd0, 8'd0, 32'h000123AB, 32'hFFFEDC55, 32'h0);
    send_item(REQ_EVAL3, 8'd0, 8'd0, 32'h00025000, 32'h00013000, 32'hFFFC8000);

    // random mix of evaluations, table rewrites and ignored codes
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (n == RANDOM_ITEMS / 2) begin
        // hold off until the pipeline is empty
        start <= 1'b0;
        while (sb.pending_noise.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      if (r < 40)
        send_item(REQ_EVAL2, 8'($urandom), 8'($urandom), rand_coord(), rand_coord(),
                  $urandom);
      else if (r < 80)
        send_item(REQ_EVAL3, 8'($urandom), 8'($urandom), rand_coord(), rand_coord(),
                  rand_coord());
      else if (r < 95)
        send_item(REQ_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom, $urandom);
      else
        send_item(REQ_NONE, 8'($urandom), 8'($urandom), $urandom, $urandom, $urandom);
    end

    start <= 1'b0;
    while (sb.pending_noise.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
